### sv/ftso_pkg.sv
// ----------------------------------------------------------------------------
// ftso_pkg
// Shared types and constants of the FLV tag timestamp offset core.
// ----------------------------------------------------------------------------
package ftso_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_HEADER = 2'd1;

  localparam logic [23:0] HEADER_LAST  = 24'd12;
  localparam logic [23:0] SIZE_LAST    = 24'd2;
  localparam logic [23:0] STAMP_LAST   = 24'd3;
  localparam logic [23:0] ID_LAST      = 24'd2;
  localparam logic [23:0] TAGSIZE_LAST = 24'd3;
  localparam logic [31:0] TAG_HEAD_LEN = 32'h0000_000b;
  localparam logic [7:0]  SCRIPT_TYPE  = 8'h12;

  // one burst of up to four result bytes caused by one input byte
  typedef struct packed {
    logic [1:0]      last_idx;
    logic            err;
    logic [3:0][7:0] data;
  } ftso_burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ftso_q_status_t;

endpackage

### sv/ftso_front.sv
// ----------------------------------------------------------------------------
// ftso_front
// Byte parser: tracks the FLV field, rewrites timestamps and checks tag sizes,
// and turns each accepted byte into at most one result burst.
// ----------------------------------------------------------------------------
module ftso_front import ftso_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  in_byte_i,
  input  logic        segment_start_i,
  input  logic [31:0] time_offset_i,
  input  logic        keep_header_i,
  output logic        push_o,
  output ftso_burst_t burst_o
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_TYPE, PH_SIZE, PH_STAMP, PH_ID, PH_DATA, PH_TAGSIZE, PH_ERROR
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [23:0] cnt_q, cnt_d;
  logic [23:0] size_q, size_d;
  logic [23:0] stamp_q, stamp_d;
  logic [23:0] tsb_q, tsb_d;
  logic        first_q, first_d;
  logic        drop_q, drop_d;

  logic [31:0] ts;
  logic [31:0] got;
  logic        emit;

  always_comb begin
    phase_d = segment_start_i ? PH_HEADER : phase_q;
    cnt_d   = segment_start_i ? 24'd0 : cnt_q;
    size_d  = segment_start_i ? 24'd0 : size_q;
    stamp_d = segment_start_i ? 24'd0 : stamp_q;
    tsb_d   = segment_start_i ? 24'd0 : tsb_q;
    first_d = segment_start_i ? 1'b1 : first_q;
    drop_d  = segment_start_i ? 1'b0 : drop_q;
    ts      = {in_byte_i, stamp_d} + time_offset_i;
    got     = {tsb_d, in_byte_i};
    emit    = 1'b0;
    burst_o = '0;
    burst_o.data[0] = in_byte_i;
    case (phase_d)
      PH_HEADER: begin
        emit = keep_header_i;
        if (cnt_d == HEADER_LAST) begin
          cnt_d   = 24'd0;
          phase_d = PH_TYPE;
        end else begin
          cnt_d = cnt_d + 24'd1;
        end
      end
      PH_TYPE: begin
        drop_d  = first_d && (in_byte_i == SCRIPT_TYPE);
        first_d = 1'b0;
        emit    = !drop_d;
        size_d  = 24'd0;
        cnt_d   = 24'd0;
        phase_d = PH_SIZE;
      end
      PH_SIZE: begin
        emit   = !drop_d;
        size_d = {size_d[15:0], in_byte_i};
        if (cnt_d == SIZE_LAST) begin
          cnt_d   = 24'd0;
          stamp_d = 24'd0;
          phase_d = PH_STAMP;
        end else begin
          cnt_d = cnt_d + 24'd1;
        end
      end
      PH_STAMP: begin
        if (cnt_d == STAMP_LAST) begin
          emit             = !drop_d;
          burst_o.last_idx = 2'd3;
          burst_o.data[0]  = ts[23:16];
          burst_o.data[1]  = ts[15:8];
          burst_o.data[2]  = ts[7:0];
          burst_o.data[3]  = ts[31:24];
          cnt_d            = 24'd0;
          phase_d          = PH_ID;
        end else begin
          stamp_d = {stamp_d[15:0], in_byte_i};
          cnt_d   = cnt_d + 24'd1;
        end
      end
      PH_ID: begin
        emit = !drop_d;
        if (cnt_d == ID_LAST) begin
          if (size_d == 24'd0) begin
            cnt_d   = 24'd0;
            tsb_d   = 24'd0;
            phase_d = PH_TAGSIZE;
          end else begin
            cnt_d   = size_d;
            phase_d = PH_DATA;
          end
        end else begin
          cnt_d = cnt_d + 24'd1;
        end
      end
      PH_DATA: begin
        emit  = !drop_d;
        cnt_d = cnt_d - 24'd1;
        if (cnt_d == 24'd0) begin
          tsb_d   = 24'd0;
          phase_d = PH_TAGSIZE;
        end
      end
      PH_TAGSIZE: begin
        if (cnt_d == TAGSIZE_LAST) begin
          if (got != ({8'd0, size_d} + TAG_HEAD_LEN)) begin
            emit            = 1'b1;
            burst_o.err     = 1'b1;
            burst_o.data[0] = 8'd0;
            phase_d         = PH_ERROR;
          end else begin
            emit             = !drop_d;
            burst_o.last_idx = 2'd3;
            burst_o.data[0]  = tsb_d[23:16];
            burst_o.data[1]  = tsb_d[15:8];
            burst_o.data[2]  = tsb_d[7:0];
            burst_o.data[3]  = in_byte_i;
            phase_d          = PH_TYPE;
          end
          drop_d = 1'b0;
          cnt_d  = 24'd0;
        end else begin
          tsb_d = {tsb_d[15:0], in_byte_i};
          cnt_d = cnt_d + 24'd1;
        end
      end
      default: begin
      end
    endcase
    push_o = accept_i && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      size_q  <= '0;
      stamp_q <= '0;
      tsb_q   <= '0;
      first_q <= 1'b1;
      drop_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      size_q  <= size_d;
      stamp_q <= stamp_d;
      tsb_q   <= tsb_d;
      first_q <= first_d;
      drop_q  <= drop_d;
    end
  end

endmodule

### sv/ftso_queue.sv
// ----------------------------------------------------------------------------
// ftso_queue
// Short burst queue between the parser and the output serializer.
// ----------------------------------------------------------------------------
module ftso_queue import ftso_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ftso_burst_t    push_data_i,
  input  logic           pop_i,
  output ftso_burst_t    pop_data_o,
  output ftso_q_status_t status_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);

  ftso_burst_t [QUEUE_DEPTH-1:0] slot_q;
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_DEPTH);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

### sv/ftso_back.sv
// ----------------------------------------------------------------------------
// ftso_back
// Output serializer: unpacks queued bursts, one beat per unstalled cycle.
// ----------------------------------------------------------------------------
module ftso_back import ftso_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ftso_burst_t    burst_i,
  input  ftso_q_status_t status_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o,
  output logic           size_error_o
);

  ftso_burst_t cur_q;
  logic [1:0]  idx_q;
  logic        busy_q;
  logic        take, at_last;

  assign take          = busy_q && !out_stall_i;
  assign at_last       = (idx_q == cur_q.last_idx);
  assign pop_o         = !status_i.empty && (!busy_q || (take && at_last));
  assign out_valid_o   = busy_q;
  assign out_byte_o    = cur_q.data[idx_q];
  assign last_of_run_o = at_last;
  assign size_error_o  = cur_q.err;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= burst_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

### sv/flv_tag_timestamp_offset_core.sv
// ----------------------------------------------------------------------------
// flv_tag_timestamp_offset_core
// Rewrites FLV tag timestamps by a configured offset, drops a leading script
// tag, checks previous-tag-size fields and flags mismatches.
// ----------------------------------------------------------------------------
// channel  | handshake                | payload
// in       | in_valid_i / in_stall_o  | in_byte_i, segment_start_i
// out      | out_valid_o / out_stall_i| out_byte_o, last_of_run_o, size_error_o
// cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One input beat per cycle while the burst queue has room; each beat yields
// zero to four output beats, sent one per cycle by the serializer while the
// output is not stalled. Timestamp and matching tag-size fields come out as
// four-beat bursts; the serializer draining the queue sets the sustained rate.
// Reset clears parse state, queue and offset; keep_header resets to one.
// A stall on the output backs up the queue, then stalls the input.
// ----------------------------------------------------------------------------
module flv_tag_timestamp_offset_core import ftso_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  segment_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o,
  output logic                  size_error_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [31:0]    time_offset_q;
  logic           keep_header_q;
  logic           accept, push, pop;
  ftso_burst_t    push_data, pop_data;
  ftso_q_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_offset_q <= '0;
      keep_header_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TIME_OFFSET: time_offset_q <= cfg_data_i[31:0];
        CFG_KEEP_HEADER: keep_header_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  ftso_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .segment_start_i (segment_start_i),
    .time_offset_i   (time_offset_q),
    .keep_header_i   (keep_header_q),
    .push_o          (push),
    .burst_o         (push_data)
  );

  ftso_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  ftso_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_i       (pop_data),
    .status_i      (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .size_error_o  (size_error_o)
  );

`ifndef SYNTHESIS
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_error_o |-> last_of_run_o && (out_byte_o == 8'd0))
    else $error("error beat is not a single zero beat");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("burst broken before its last beat");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("burst pushed into a full queue");
`endif

endmodule
